>>> hdl/jabc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jabc_pkg
// Shared types and constants for the joystick axis and button conditioner.
// ----------------------------------------------------------------------------
package jabc_pkg;

  localparam int ADC_BITS    = 10;
  localparam int NUM_BUTTONS = 4;
  localparam int TIME_BITS   = 32;
  localparam int GAIN_BITS   = 12;
  localparam int GAIN_FRAC   = 10;
  localparam int DEB_BITS    = 8;
  localparam int PROD_BITS   = ADC_BITS + GAIN_BITS;
  localparam int SHIFT_BITS  = PROD_BITS - GAIN_FRAC;
  localparam int SUM_BITS    = SHIFT_BITS + 1;

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0] ADC_MID = {1'b0, {(ADC_BITS-1){1'b1}}};

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_X_CENTER    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_GAIN_LOW  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_GAIN_HIGH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_CENTER    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_GAIN_LOW  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_GAIN_HIGH = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE    = 3'd6;

  localparam logic [ADC_BITS-1:0]  RST_X_CENTER    = 10'd592;
  localparam logic [GAIN_BITS-1:0] RST_X_GAIN_LOW  = 12'd881;
  localparam logic [GAIN_BITS-1:0] RST_X_GAIN_HIGH = 12'd1219;
  localparam logic [ADC_BITS-1:0]  RST_Y_CENTER    = 10'd433;
  localparam logic [GAIN_BITS-1:0] RST_Y_GAIN_LOW  = 12'd1208;
  localparam logic [GAIN_BITS-1:0] RST_Y_GAIN_HIGH = 12'd891;
  localparam logic [DEB_BITS-1:0]  RST_DEBOUNCE    = 8'd10;

  typedef struct packed {
    logic [ADC_BITS-1:0]    x_raw;
    logic [ADC_BITS-1:0]    y_raw;
    logic [NUM_BUTTONS-1:0] button_levels;
    logic [TIME_BITS-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]    x_out;
    logic [ADC_BITS-1:0]    y_out;
    logic [NUM_BUTTONS-1:0] pressed_mask;
  } out_item_t;

  // Stage load enables handed from the top level to the axis lanes.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctl_t;

endpackage
`default_nettype wire

>>> hdl/jabc_axis_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jabc_axis_lane
// One axis: two-sample average, segment select, gain multiply, offset and
// saturation. Two register stages; the shaped value is valid after stage two.
// ----------------------------------------------------------------------------
module jabc_axis_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire jabc_pkg::pipe_ctl_t             ctl,
  input  wire logic [jabc_pkg::ADC_BITS-1:0]   raw,
  input  wire logic [jabc_pkg::ADC_BITS-1:0]   center,
  input  wire logic [jabc_pkg::GAIN_BITS-1:0]  gain_low,
  input  wire logic [jabc_pkg::GAIN_BITS-1:0]  gain_high,
  output logic      [jabc_pkg::ADC_BITS-1:0]   shaped
);
  import jabc_pkg::*;

  logic [ADC_BITS-1:0]   prev_r;
  logic [ADC_BITS:0]     pair_sum;
  logic [ADC_BITS-1:0]   avg;
  logic                  upper;
  logic [ADC_BITS-1:0]   op_nxt;
  logic [ADC_BITS-1:0]   op_r;
  logic [GAIN_BITS-1:0]  gain_r;
  logic                  upper1_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic                  upper2_r;
  logic [SHIFT_BITS-1:0] scaled;
  logic [SUM_BITS-1:0]   total;

  assign pair_sum = {1'b0, raw} + {1'b0, prev_r};
  assign avg      = pair_sum[ADC_BITS:1];
  assign upper    = (avg >= center);
  assign op_nxt   = upper ? (avg - center) : avg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ctl.s1_en) begin
      prev_r <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      op_r     <= op_nxt;
      gain_r   <= upper ? gain_high : gain_low;
      upper1_r <= upper;
    end
    if (ctl.s2_en) begin
      prod_r   <= PROD_BITS'(op_r) * PROD_BITS'(gain_r);
      upper2_r <= upper1_r;
    end
  end

  assign scaled = prod_r[PROD_BITS-1:GAIN_FRAC];
  assign total  = upper2_r ? ({1'b0, scaled} + SUM_BITS'(ADC_MID)) : {1'b0, scaled};
  assign shaped = (total > SUM_BITS'(ADC_MAX)) ? ADC_MAX : total[ADC_BITS-1:0];

endmodule
`default_nettype wire

>>> hdl/jabc_button_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jabc_button_lane
// Lockout debounce for one button. A level change is taken at once and
// opens a window during which the pin is ignored.
// ----------------------------------------------------------------------------
module jabc_button_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire logic                            pin,
  input  wire logic [jabc_pkg::TIME_BITS-1:0]  now_ms,
  input  wire logic [jabc_pkg::DEB_BITS-1:0]   debounce_ms,
  output logic                                 pressed
);
  import jabc_pkg::*;

  logic                 level_r;
  logic                 level_nxt;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] start_nxt;
  logic                 busy_r;
  logic                 busy_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic                 locked;

  // Modulo subtraction keeps the window test correct across time stamp wrap.
  assign elapsed = now_ms - start_r;
  assign locked  = busy_r && (elapsed < TIME_BITS'(debounce_ms));

  always_comb begin
    level_nxt = level_r;
    start_nxt = start_r;
    busy_nxt  = busy_r && locked;
    if (!locked && (pin != level_r)) begin
      level_nxt = pin;
      start_nxt = now_ms;
      busy_nxt  = 1'b1;
    end
  end

  // The updated level is reported for the same item.
  assign pressed = !level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b1;
      start_r <= '0;
      busy_r  <= 1'b0;
    end else if (accept) begin
      level_r <= level_nxt;
      start_r <= start_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/joystick_axis_button_conditioner_core.sv
`default_nettype none
// An accepted item passes stage one, stage two and the merge register before it reaches out_valid/out_data.
// Throughput: one item per cycle; the three register stages collapse bubbles,
// so in_ready drops only when all three hold items and out_ready is low.
// Reset (synchronous, rst_n low) empties the pipeline, restores the register
// defaults, clears the averaging history and releases all buttons.
// ----------------------------------------------------------------------------
// joystick_axis_button_conditioner_core
// Two axis lanes and a row of button lanes work on each item side by side;
// the merge stage joins the shaped axes and the pressed mask into one result.
// ----------------------------------------------------------------------------
module joystick_axis_button_conditioner_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire jabc_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output jabc_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [jabc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [jabc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import jabc_pkg::*;

  logic [ADC_BITS-1:0]    x_center_r;
  logic [GAIN_BITS-1:0]   x_gain_low_r;
  logic [GAIN_BITS-1:0]   x_gain_high_r;
  logic [ADC_BITS-1:0]    y_center_r;
  logic [GAIN_BITS-1:0]   y_gain_low_r;
  logic [GAIN_BITS-1:0]   y_gain_high_r;
  logic [DEB_BITS-1:0]    debounce_r;

  logic                   v1_r;
  logic                   v1_nxt;
  logic                   v2_r;
  logic                   v2_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   can1;
  logic                   can2;
  logic                   can3;
  logic                   accept;
  logic                   s3_load;
  pipe_ctl_t              ctl;

  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] mask1_r;
  logic [NUM_BUTTONS-1:0] mask2_r;
  logic [ADC_BITS-1:0]    x_shaped;
  logic [ADC_BITS-1:0]    y_shaped;
  out_item_t              out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r    <= RST_X_CENTER;
      x_gain_low_r  <= RST_X_GAIN_LOW;
      x_gain_high_r <= RST_X_GAIN_HIGH;
      y_center_r    <= RST_Y_CENTER;
      y_gain_low_r  <= RST_Y_GAIN_LOW;
      y_gain_high_r <= RST_Y_GAIN_HIGH;
      debounce_r    <= RST_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_CENTER:    x_center_r    <= cfg_wdata[ADC_BITS-1:0];
        CFG_X_GAIN_LOW:  x_gain_low_r  <= cfg_wdata[GAIN_BITS-1:0];
        CFG_X_GAIN_HIGH: x_gain_high_r <= cfg_wdata[GAIN_BITS-1:0];
        CFG_Y_CENTER:    y_center_r    <= cfg_wdata[ADC_BITS-1:0];
        CFG_Y_GAIN_LOW:  y_gain_low_r  <= cfg_wdata[GAIN_BITS-1:0];
        CFG_Y_GAIN_HIGH: y_gain_high_r <= cfg_wdata[GAIN_BITS-1:0];
        CFG_DEBOUNCE:    debounce_r    <= cfg_wdata[DEB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage may load when it is empty or its item moves on.
  assign can3        = !out_valid_r || out_ready;
  assign can2        = !v2_r || can3;
  assign can1        = !v1_r || can2;
  assign in_ready    = can1;
  assign accept      = in_valid && in_ready;
  assign ctl.s1_en   = accept;
  assign ctl.s2_en   = v1_r && can2;
  assign s3_load     = v2_r && can3;

  always_comb begin
    v1_nxt        = accept ? 1'b1 : (ctl.s2_en ? 1'b0 : v1_r);
    v2_nxt        = ctl.s2_en ? 1'b1 : (s3_load ? 1'b0 : v2_r);
    out_valid_nxt = s3_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  jabc_axis_lane u_x_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .raw       (in_data.x_raw),
    .center    (x_center_r),
    .gain_low  (x_gain_low_r),
    .gain_high (x_gain_high_r),
    .shaped    (x_shaped)
  );

  jabc_axis_lane u_y_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .raw       (in_data.y_raw),
    .center    (y_center_r),
    .gain_low  (y_gain_low_r),
    .gain_high (y_gain_high_r),
    .shaped    (y_shaped)
  );

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    jabc_button_lane u_btn (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .pin         (in_data.button_levels[i]),
      .now_ms      (in_data.now_ms),
      .debounce_ms (debounce_r),
      .pressed     (pressed[i])
    );
  end

  // The mask travels alongside the axis stages so all fields stay aligned.
  always_ff @(posedge clk) begin
    if (accept) begin
      mask1_r <= pressed;
    end
    if (ctl.s2_en) begin
      mask2_r <= mask1_r;
    end
    if (s3_load) begin
      out_r.x_out        <= x_shaped;
      out_r.y_out        <= y_shaped;
      out_r.pressed_mask <= mask2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> hdl/jabc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jabc_checker
// Port-level checks on the conditioner core, bound to the top level.
// ----------------------------------------------------------------------------
module jabc_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire jabc_pkg::out_item_t  out_data
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled full output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // With the output side taking results, an accepted item reaches out_valid once through the stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output in time");

endmodule

bind joystick_axis_button_conditioner_core jabc_checker u_jabc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
